FILE: hdl/zssd_pkg.sv
// shared types and constants of the zero-suppressed segment deframer
package zssd_pkg;

  // item actions
  localparam logic [1:0] ACT_NEW_FRAGMENT = 2'd0;
  localparam logic [1:0] ACT_RAW_HEADER   = 2'd1;
  localparam logic [1:0] ACT_DATA_WORD    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // configuration register indexes
  localparam logic CFG_SAVE_FIRST  = 1'b0;
  localparam logic CFG_SAVE_SECOND = 1'b1;

  // largest fragment in data words
  localparam logic [16:0] MAX_FRAGMENT_WORDS = 17'd65536;

  // result queue depth
  localparam int          RQ_DEPTH   = 4;
  localparam int          RQ_PTR_W   = $clog2(RQ_DEPTH);
  localparam int          RQ_CNT_W   = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  action;
    logic        detector;
    logic [15:0] data_word;
    logic [16:0] words_left;
    logic [15:0] header_regions;
    logic [15:0] header_length;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        segment_offset;
    logic signed [15:0] sample_value;
    logic               segment_end;
    logic [15:0]        segment_number;
    logic [15:0]        summary_regions;
    logic [15:0]        summary_length;
    logic               length_error;
    logic               last;
  } result_t;

  // results produced by one item, first slot used first
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

FILE: hdl/zssd_parser.sv
// segment parse state and per-word result generation
module zssd_parser import zssd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  item_t        item,
  input  logic         save_first_detector,
  input  logic         save_second_detector,
  output result_pair_t results
);

  localparam logic [1:0] PH_LOC    = 2'd0;
  localparam logic [1:0] PH_SIZE   = 2'd1;
  localparam logic [1:0] PH_SAMPLE = 2'd2;

  logic [1:0]  parse_phase, parse_phase_next;
  logic [15:0] current_offset, current_offset_next;
  logic [15:0] samples_remaining, samples_remaining_next;
  logic [15:0] region_count, region_count_next;
  logic [15:0] length_total, length_total_next;
  logic        check_armed, check_armed_next;
  logic [15:0] expected_regions, expected_regions_next;
  logic [15:0] expected_length, expected_length_next;
  logic        parse_stopped, parse_stopped_next;

  logic [16:0] wl;
  logic        is_last;
  logic        save;
  logic        emit;
  logic [16:0] len_sum;
  result_t     primary;
  result_t     summary;

  always_comb begin
    // clamp words left into the legal fragment range
    if (item.words_left > MAX_FRAGMENT_WORDS) begin
      wl = MAX_FRAGMENT_WORDS;
    end else if (item.words_left == 17'd0) begin
      wl = 17'd1;
    end else begin
      wl = item.words_left;
    end
    is_last = (wl == 17'd1);
    save    = item.detector ? save_second_detector : save_first_detector;
    len_sum = {1'b0, length_total} + {1'b0, item.data_word};

    parse_phase_next       = parse_phase;
    current_offset_next    = current_offset;
    samples_remaining_next = samples_remaining;
    region_count_next      = region_count;
    length_total_next      = length_total;
    check_armed_next       = check_armed;
    expected_regions_next  = expected_regions;
    expected_length_next   = expected_length;
    parse_stopped_next     = parse_stopped;

    emit    = 1'b0;
    primary = '0;
    summary = '0;

    unique case (item.action)
      ACT_NEW_FRAGMENT: begin
        parse_phase_next       = PH_LOC;
        current_offset_next    = '0;
        samples_remaining_next = '0;
        region_count_next      = '0;
        length_total_next      = '0;
        parse_stopped_next     = 1'b0;
        check_armed_next       = 1'b0;
        expected_regions_next  = '0;
        expected_length_next   = '0;
      end
      ACT_RAW_HEADER: begin
        expected_regions_next = item.header_regions;
        expected_length_next  = item.header_length;
        check_armed_next      = 1'b1;
      end
      ACT_DATA_WORD: begin
        // segment parse step
        if (!parse_stopped) begin
          unique case (parse_phase)
            PH_SIZE: begin
              if ({1'b0, item.data_word} >= wl) begin
                parse_stopped_next = 1'b1;
              end else begin
                if (region_count != 16'hFFFF) begin
                  region_count_next = region_count + 16'd1;
                end
                length_total_next = len_sum[16] ? 16'hFFFF : len_sum[15:0];
                if (item.data_word == 16'd0) begin
                  emit                   = save;
                  primary.kind           = KIND_EMPTY;
                  primary.segment_offset = current_offset;
                  primary.segment_end    = 1'b1;
                  primary.segment_number = region_count_next - 16'd1;
                  parse_phase_next       = PH_LOC;
                end else begin
                  samples_remaining_next = item.data_word;
                  parse_phase_next       = PH_SAMPLE;
                end
              end
            end
            PH_SAMPLE: begin
              emit                   = save;
              primary.kind           = KIND_SAMPLE;
              primary.segment_offset = current_offset;
              primary.sample_value   = $signed(item.data_word);
              primary.segment_end    = (samples_remaining <= 16'd1);
              primary.segment_number = region_count - 16'd1;
              if (samples_remaining <= 16'd1) begin
                samples_remaining_next = '0;
                parse_phase_next       = PH_LOC;
              end else begin
                samples_remaining_next = samples_remaining - 16'd1;
              end
            end
            default: begin
              if ((check_armed && region_count >= expected_regions) || wl < 17'd2) begin
                parse_stopped_next = 1'b1;
              end else begin
                current_offset_next = item.data_word;
                parse_phase_next    = PH_SIZE;
              end
            end
          endcase
        end

        // fragment summary on the last word
        summary.kind            = KIND_SUMMARY;
        summary.summary_regions = region_count_next;
        summary.summary_length  = length_total_next;
        summary.length_error    = check_armed && (length_total_next != expected_length);
        summary.last            = 1'b1;
        primary.last            = !is_last;
        if (is_last) begin
          parse_phase_next       = PH_LOC;
          current_offset_next    = '0;
          samples_remaining_next = '0;
          region_count_next      = '0;
          length_total_next      = '0;
          parse_stopped_next     = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // pack results in order
    results = '0;
    if (item.action == ACT_DATA_WORD) begin
      if (emit && is_last) begin
        results.count  = 2'd2;
        results.first  = primary;
        results.second = summary;
      end else if (emit) begin
        results.count = 2'd1;
        results.first = primary;
      end else if (is_last) begin
        results.count = 2'd1;
        results.first = summary;
      end
    end
    if (!fire) begin
      results.count = 2'd0;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_LOC;
      current_offset    <= '0;
      samples_remaining <= '0;
      region_count      <= '0;
      length_total      <= '0;
      check_armed       <= 1'b0;
      expected_regions  <= '0;
      expected_length   <= '0;
      parse_stopped     <= 1'b0;
    end else if (fire) begin
      parse_phase       <= parse_phase_next;
      current_offset    <= current_offset_next;
      samples_remaining <= samples_remaining_next;
      region_count      <= region_count_next;
      length_total      <= length_total_next;
      check_armed       <= check_armed_next;
      expected_regions  <= expected_regions_next;
      expected_length   <= expected_length_next;
      parse_stopped     <= parse_stopped_next;
    end
  end

endmodule

FILE: hdl/zssd_result_fifo.sv
// small result queue taking up to two results per cycle and giving one unless stalled
module zssd_result_fifo import zssd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  result_pair_t push,
  input  logic         result_stall,
  output logic         result_valid,
  output result_t      result,
  output logic         room
);

  result_t             mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_CNT_W-1:0] count;
  logic                pop;

  assign result_valid = (count != '0);
  assign result       = mem[rd_ptr];
  assign pop          = result_valid && !result_stall;
  assign room         = (count <= RQ_CNT_W'(RQ_DEPTH - 2));

  // storage writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + RQ_PTR_W'(1)] <= push.second;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + RQ_PTR_W'(1);
      end
      count <= count + RQ_CNT_W'(push.count) - RQ_CNT_W'(pop);
    end
  end

endmodule

FILE: hdl/zs_segment_deframer.sv
// top level of the zero-suppressed segment deframer
//
// Usage: fragment words enter on the item channel (item_valid / item_stall /
// item), results leave on the result channel (result_valid / result_stall /
// result). A transaction happens on a rising edge with valid high and stall
// low. The two detector save enables are written through cfg_write,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. Each accepted item is held
// in an input register, parsed there, and its results are written to the
// result queue, which drives the result port. Throughput is one item per
// cycle while items make at most one result and the queue has room; a last
// data word that also carries a sample or marker makes two results, which
// leave one at a time through the single read port of the result queue.
// When the receiver stalls, results collect in a four-entry queue; once it
// cannot take two more results the held item waits and item_stall rises.
// Reset clears the parse state, the length check, the save enables and the
// queue; the block accepts items in the first cycle after reset.
module zs_segment_deframer import zssd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result,
  input  logic    cfg_write,
  input  logic    cfg_index,
  input  logic    cfg_data
);

  logic         save_first_detector;
  logic         save_second_detector;
  logic         held_valid;
  item_t        held_item;
  logic         room;
  logic         fire;
  result_pair_t results;

  assign fire       = held_valid && room;
  assign item_stall = held_valid && !room;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      save_first_detector  <= 1'b0;
      save_second_detector <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SAVE_FIRST:  save_first_detector  <= cfg_data;
        CFG_SAVE_SECOND: save_second_detector <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      held_item <= item;
    end
  end

  zssd_parser u_parser (
    .clk                  (clk),
    .rst                  (rst),
    .fire                 (fire),
    .item                 (held_item),
    .save_first_detector  (save_first_detector),
    .save_second_detector (save_second_detector),
    .results              (results)
  );

  zssd_result_fifo u_result_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (results),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .room         (room)
  );

endmodule

FILE: tb/tb_top.sv
// testbench for zs_segment_deframer: directed table and random fragments
`timescale 1ns / 1ps

module tb_top;
  import zssd_pkg::*;

  // action code the block ignores
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // cycles allowed for an item with no result to leave the pipeline
  localparam int SETTLE_CYCLES = 8;
  // no transaction for this long means the block hung; a 72 percent idle
  // side never comes close to this
  localparam int QUIET_LIMIT = 2000;

  typedef enum logic [1:0] {AT_LOCATION, AT_SIZE, IN_SAMPLES} deframe_phase_e;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  logic    cfg_write;
  logic    cfg_index;
  logic    cfg_data;

  zs_segment_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state, mirrors the block
  deframe_phase_e frag_phase   = AT_LOCATION;
  logic [15:0]    seg_offset   = '0;
  logic [15:0]    samples_left = '0;
  logic [15:0]    regions_seen = '0;
  logic [15:0]    length_seen  = '0;
  logic           check_on     = 1'b0;
  logic [15:0]    want_regions = '0;
  logic [15:0]    want_length  = '0;
  logic           halted       = 1'b0;
  logic           save_first   = 1'b0;
  logic           save_second  = 1'b0;

  result_t   expected_results[$];
  stim_row_t stim_rows[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int summaries_seen = 0;
  int length_errors_seen = 0;
  int quiet_cycles = 0;

  function automatic item_t make_item(input logic [1:0] act, input logic det,
                                      input logic [15:0] w, input logic [16:0] wl,
                                      input logic [15:0] hr, input logic [15:0] hl);
    item_t it;
    it.action         = act;
    it.detector       = det;
    it.data_word      = w;
    it.words_left     = wl;
    it.header_regions = hr;
    it.header_length  = hl;
    return it;
  endfunction

  function automatic result_t make_result(input logic [1:0] kind, input logic [15:0] off,
                                          input logic [15:0] val, input logic seg_end,
                                          input logic [15:0] segnum, input logic [15:0] regs,
                                          input logic [15:0] len, input logic lerr,
                                          input logic last);
    result_t r;
    r.kind            = kind;
    r.segment_offset  = off;
    r.sample_value    = val;
    r.segment_end     = seg_end;
    r.segment_number  = segnum;
    r.summary_regions = regs;
    r.summary_length  = len;
    r.length_error    = lerr;
    r.last            = last;
    return r;
  endfunction

  // per-fragment parse state back to its reset value
  function automatic void reset_fragment();
    frag_phase   = AT_LOCATION;
    seg_offset   = '0;
    samples_left = '0;
    regions_seen = '0;
    length_seen  = '0;
    halted       = 1'b0;
  endfunction

  // advance the deframer by one item, return how many results it causes
  function automatic int deframe_item(input item_t it, output result_t r0,
                                      output result_t r1);
    logic [16:0] left;
    logic [16:0] sum;
    logic        save;
    logic        seg_last;
    result_t     summary;
    int          n;
    n  = 0;
    r0 = '0;
    r1 = '0;
    case (it.action)
      ACT_NEW_FRAGMENT: begin
        reset_fragment();
        check_on     = 1'b0;
        want_regions = '0;
        want_length  = '0;
        return 0;
      end
      ACT_RAW_HEADER: begin
        want_regions = it.header_regions;
        want_length  = it.header_length;
        check_on     = 1'b1;
        return 0;
      end
      ACT_DATA_WORD: ;
      default: return 0;
    endcase

    left = it.words_left;
    if (left > MAX_FRAGMENT_WORDS) left = MAX_FRAGMENT_WORDS;
    if (left == 17'd0) left = 17'd1;
    save = it.detector ? save_second : save_first;

    if (!halted) begin
      case (frag_phase)
        AT_SIZE: begin
          // a size that overruns the fragment stops parsing
          if ({1'b0, it.data_word} > left - 17'd1) begin
            halted = 1'b1;
          end else begin
            sum = {1'b0, length_seen} + {1'b0, it.data_word};
            if (regions_seen != 16'hFFFF) regions_seen++;
            length_seen = sum[16] ? 16'hFFFF : sum[15:0];
            if (it.data_word == 16'd0) begin
              if (save) begin
                r0 = make_result(KIND_EMPTY, seg_offset, 16'd0, 1'b1, regions_seen - 16'd1,
                                 16'd0, 16'd0, 1'b0, 1'b0);
                n = 1;
              end
              frag_phase = AT_LOCATION;
            end else begin
              samples_left = it.data_word;
              frag_phase   = IN_SAMPLES;
            end
          end
        end
        IN_SAMPLES: begin
          seg_last = (samples_left <= 16'd1);
          if (save) begin
            r0 = make_result(KIND_SAMPLE, seg_offset, it.data_word, seg_last,
                             regions_seen - 16'd1, 16'd0, 16'd0, 1'b0, 1'b0);
            n = 1;
          end
          if (seg_last) begin
            samples_left = '0;
            frag_phase   = AT_LOCATION;
          end else begin
            samples_left--;
          end
        end
        default: begin
          // region limit or no room for a size word
          if ((check_on && regions_seen >= want_regions) || left < 17'd2) begin
            halted = 1'b1;
          end else begin
            seg_offset = it.data_word;
            frag_phase = AT_SIZE;
          end
        end
      endcase
    end

    // last word of the fragment adds the summary
    if (left == 17'd1) begin
      summary = make_result(KIND_SUMMARY, 16'd0, 16'd0, 1'b0, 16'd0, regions_seen,
                            length_seen, check_on && (length_seen != want_length), 1'b0);
      if (n == 0) r0 = summary;
      else r1 = summary;
      n++;
      reset_fragment();
    end

    if (n == 1) r0.last = 1'b1;
    else if (n == 2) r1.last = 1'b1;
    return n;
  endfunction

  // one item transaction, with random idle cycles ahead of it
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    result_t r0;
    result_t r1;
    int      n;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    n = deframe_item(it, r0, r1);
    if (typed) begin
      expected_results.push_back(want);
    end else begin
      if (n > 0) expected_results.push_back(r0);
      if (n > 1) expected_results.push_back(r1);
    end
    if (it.action != ACT_UNUSED) items_sent++;
  endtask

  // stop sending and wait for the block to go idle
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_saves(input logic first, input logic second);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SAVE_FIRST;
    cfg_data  <= first;
    @(posedge clk);
    cfg_index <= CFG_SAVE_SECOND;
    cfg_data  <= second;
    @(posedge clk);
    cfg_write   <= 1'b0;
    save_first  = first;
    save_second = second;
  endtask

  function automatic void add_row(input item_t it, input bit typed, input result_t want);
    stim_row_t row;
    row.it    = it;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endfunction

  // one fragment: optional new-fragment and header, then well-formed segments
  // with random content, sometimes broken, cut short or mixed with noise
  task automatic play_fragment();
    logic [15:0] words[$];
    logic [16:0] left;
    logic        det;
    int          n;
    int          rem;
    int          sz;
    int          segs;
    int          total;
    int          hr;
    int          hl;
    int          cut;
    int          i;
    n     = ($urandom_range(7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 14);
    det   = 1'($urandom_range(1));
    segs  = 0;
    total = 0;
    while (words.size() < n) begin
      words.push_back(16'($urandom));
      rem = n - words.size();
      if (rem > 0) begin
        if ($urandom_range(11) == 0) begin
          sz = rem + $urandom_range(0, 3);
        end else begin
          sz = $urandom_range(0, 5);
          if (sz > rem - 1) sz = rem - 1;
        end
        words.push_back(sz[15:0]);
        segs++;
        total += sz;
        for (i = 0; i < sz && words.size() < n; i++) words.push_back(16'($urandom));
      end
    end

    if ($urandom_range(2) == 0)
      send_item(make_item(ACT_NEW_FRAGMENT, 1'($urandom_range(1)), 16'($urandom),
                          17'($urandom_range(0, 131071)), 16'($urandom), 16'($urandom)),
                1'b0, '0);
    if ($urandom_range(1) == 0) begin
      hr = ($urandom_range(7) == 0) ? $urandom_range(0, 65535) : segs + $urandom_range(0, 2) - 1;
      hl = ($urandom_range(7) == 0) ? $urandom_range(0, 65535) : total + $urandom_range(0, 2) - 1;
      if (hr < 0) hr = 0;
      if (hl < 0) hl = 0;
      send_item(make_item(ACT_RAW_HEADER, 1'($urandom_range(1)), 16'($urandom),
                          17'($urandom_range(0, 131071)), hr[15:0], hl[15:0]), 1'b0, '0);
    end

    cut = ($urandom_range(19) == 0) ? $urandom_range(1, n) : n;
    for (i = 0; i < cut; i++) begin
      // noise: ignored action or a stray data word
      if ($urandom_range(24) == 0)
        send_item(make_item(($urandom_range(3) == 0) ? ACT_DATA_WORD : ACT_UNUSED,
                            1'($urandom_range(1)), 16'($urandom),
                            17'($urandom_range(0, 131071)), 16'($urandom), 16'($urandom)),
                  1'b0, '0);
      left = 17'(n - i);
      if (left == 17'd1 && $urandom_range(9) == 0) left = 17'd0;
      else if (left > 17'd1 && $urandom_range(29) == 0) left = 17'($urandom_range(65537, 131071));
      send_item(make_item(ACT_DATA_WORD, ($urandom_range(19) == 0) ? ~det : det, words[i],
                          left, 16'($urandom), 16'($urandom)), 1'b0, '0);
    end
  endtask

  // result checking and receiver stalls
  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected, got %h", $time, got);
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (want.kind == KIND_SUMMARY) summaries_seen++;
    if (want.length_error) length_errors_seen++;
    check_field("kind", 17'(want.kind), 17'(got.kind));
    check_field("segment_offset", 17'(want.segment_offset), 17'(got.segment_offset));
    check_field("sample_value", 17'(want.sample_value), 17'(got.sample_value));
    check_field("segment_end", 17'(want.segment_end), 17'(got.segment_end));
    check_field("segment_number", 17'(want.segment_number), 17'(got.segment_number));
    check_field("summary_regions", 17'(want.summary_regions), 17'(got.summary_regions));
    check_field("summary_length", 17'(want.summary_length), 17'(got.summary_length));
    check_field("length_error", 17'(want.length_error), 17'(got.length_error));
    check_field("last", 17'(want.last), 17'(got.last));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) check_result(result);
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, expected_results.size());
      $display("** zs_segment_deframer: FAILED **");
      $finish;
    end
  end

  // stimulus
  initial begin
    int i;
    int ph;
    int goal;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_stall = 1'b0;
    cfg_write    = 1'b0;
    cfg_index    = CFG_SAVE_FIRST;
    cfg_data     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // saves still at reset: empty segment gives only the summary
    add_row(make_item(ACT_UNUSED, 1'b1, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'h1111, 17'd2, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'h0000, 17'd1, 16'd0, 16'd0), 1'b1,
            make_result(KIND_SUMMARY, 16'd0, 16'd0, 1'b0, 16'd0, 16'd1, 16'd0, 1'b0, 1'b1));
    // both saves on from here: empty segment, full segment ending the fragment
    add_row(make_item(ACT_NEW_FRAGMENT, 1'b0, 16'h0000, 17'd0, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_RAW_HEADER, 1'b1, 16'h0000, 17'd0, 16'd2, 16'd3), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'hFFFF, 17'd7, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'h0000, 17'd6, 16'd0, 16'd0), 1'b1,
            make_result(KIND_EMPTY, 16'hFFFF, 16'd0, 1'b1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1));
    add_row(make_item(ACT_DATA_WORD, 1'b1, 16'h0000, 17'd5, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b1, 16'h0003, 17'd4, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b1, 16'h8000, 17'd3, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b1, 16'h7FFF, 17'd2, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'hFFFF, 17'd1, 16'd0, 16'd0), 1'b0, '0);
    // region limit, then a zero words_left word ends the fragment with a length error
    add_row(make_item(ACT_RAW_HEADER, 1'b0, 16'h0000, 17'd0, 16'd1, 16'd5), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'h1234, 17'd10, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'h0001, 17'd9, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'h0001, 17'd8, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'h5555, 17'd7, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'hAAAA, 17'd6, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'h0000, 17'd0, 16'd0, 16'd0), 1'b1,
            make_result(KIND_SUMMARY, 16'd0, 16'd0, 1'b0, 16'd0, 16'd1, 16'd1, 1'b1, 1'b1));
    // size overrun and location overrun
    add_row(make_item(ACT_NEW_FRAGMENT, 1'b1, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b1, 16'h00FF, 17'd3, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b1, 16'h0005, 17'd2, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b1, 16'h0000, 17'd1, 16'd0, 16'd0), 1'b1,
            make_result(KIND_SUMMARY, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1));
    add_row(make_item(ACT_DATA_WORD, 1'b1, 16'hBEEF, 17'd1, 16'd0, 16'd0), 1'b1,
            make_result(KIND_SUMMARY, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1));
    // oversized words_left is clamped, largest size accepted
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'h0042, 17'h1FFFF, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'hFFFF, 17'h10000, 16'd0, 16'd0), 1'b0, '0);
    add_row(make_item(ACT_NEW_FRAGMENT, 1'b0, 16'h0000, 17'd0, 16'd0, 16'd0), 1'b0, '0);
    // all-ones header, empty fragment flags the length
    add_row(make_item(ACT_RAW_HEADER, 1'b0, 16'h0000, 17'd0, 16'hFFFF, 16'hFFFF), 1'b0, '0);
    add_row(make_item(ACT_DATA_WORD, 1'b0, 16'h0000, 17'd1, 16'd0, 16'd0), 1'b1,
            make_result(KIND_SUMMARY, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
    add_row(make_item(ACT_NEW_FRAGMENT, 1'b0, 16'h0000, 17'd0, 16'd0, 16'd0), 1'b0, '0);

    send_idle_pct = 19;
    recv_idle_pct = 72;
    for (i = 0; i < stim_rows.size(); i++) begin
      if (i == 3) begin
        settle();
        set_saves(1'b1, 1'b1);
      end
      send_item(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].want);
    end

    // random fragments under each idle pattern and save setting
    for (ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: set_saves(1'b1, 1'b1);
        1: set_saves(1'b0, 1'b1);
        2: set_saves(1'b1, 1'b0);
        3: set_saves(1'b1, 1'b1);
        4: set_saves(1'b0, 1'b0);
        default: set_saves(1'b1, 1'b1);
      endcase
      send_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 72 : 0;
      recv_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 19 : 0;
      goal = items_sent + 200;
      while (items_sent < goal) play_fragment();
    end

    settle();
    $display("covered %0d items over directed rows and random fragments, %0d results checked",
             items_sent, results_checked);
    $display("%0d fragment summaries, %0d with a length mismatch, %0d mismatches found",
             summaries_seen, length_errors_seen, errors);
    if (errors == 0)
      $display("** zs_segment_deframer: PASSED **");
    else
      $display("** zs_segment_deframer: FAILED **");
    $finish;
  end

endmodule
